FILE: rtl/hdlc_frame_receiver_crc16_macros.svh
// ----------------------------------------------------------------------------
// hdlc frame receiver assertion macros
// shared concurrent assertion forms, sampled on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef HDLC_FRAME_RECEIVER_CRC16_MACROS_SVH
`define HDLC_FRAME_RECEIVER_CRC16_MACROS_SVH

// condition holds at every edge outside reset
`define HFR_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define HFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// consequent holds in the same cycle as the antecedent
`define HFR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/hfr_pkg.sv
// ----------------------------------------------------------------------------
// hfr_pkg
// constants of the hdlc frame receiver: octet codes, crc setup, csr map
// ----------------------------------------------------------------------------
package hfr_pkg;

   // framing octets
   localparam logic [7:0] FLAG_OCTET = 8'h7E;
   localparam logic [7:0] ESC_OCTET  = 8'h7D;
   localparam logic [7:0] FLIP_MASK  = 8'h20;

   // reflected crc-16/ccitt
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;

   // frame store depth default
   localparam int MAX_FRAME_DEFAULT = 32;

   // csr map
   localparam int          CSR_ADDR_W       = 2;
   localparam logic [1:0]  CSR_MAX_LEN_ADDR = 2'd0;
   localparam logic [5:0]  MAX_LEN_RESET    = 6'd32;

endpackage

FILE: rtl/hdlc_frame_receiver_crc16.sv
// ----------------------------------------------------------------------------
// hdlc_frame_receiver_crc16
// deframes raw octets of an async hdlc link, checks crc-16 and emits payload
// ----------------------------------------------------------------------------
// Input channel req_*: one raw octet per transfer (req_valid / req_stall).
// Output channel rsp_*: one payload octet per transfer with its index and a
// last mark; a good frame with no payload gives one transfer with
// rsp_payload_valid low and rsp_last high.
// Config: csr_* apb-style port, frame length limit register at byte address 0.
// Flow: a flag, an escape, one of the first two octets of a frame or the
// octet that reaches the length limit needs no crc work; any other octet is
// accepted and then passes through the bit-serial crc unit, which handles one
// bit per cycle. A closing flag of a good frame then runs a frame store read
// and an output register load for each payload octet (one of each for an
// empty payload); req_stall stays high meanwhile.
// The output register holds one result; while it waits under rsp_stall the
// read loop holds and req_stall stays high. Once the last result of a frame
// is loaded the block takes octets again while that result waits.
// Reset: synchronous; clears the frame in progress, the escape state and the
// output valid, and sets the frame length limit to 32. The frame store is not
// cleared: only octets written in the current frame are read.
// ----------------------------------------------------------------------------
module hdlc_frame_receiver_crc16 #(
   parameter int MAX_FRAME = hfr_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // input octets
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_rx_byte,
   // payload results
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_payload_byte,
   output logic                          rsp_payload_valid,
   output logic [4:0]                    rsp_byte_index,
   output logic                          rsp_last,
   // configuration
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [hfr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   `include "hdlc_frame_receiver_crc16_macros.svh"

   localparam int IW = $clog2(MAX_FRAME);
   localparam int CW = $clog2(MAX_FRAME + 1);
   localparam int LW = (CW > 6) ? CW : 6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CRC,
      ST_READ,
      ST_LOAD
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [15:0]     crc_ff, crc_in;
   logic            esc_ff, esc_in;
   logic [2:0]      bit_cnt_ff, bit_cnt_in;
   logic [7:0]      newest_ff, newest_in;
   logic [7:0]      second_ff, second_in;
   logic [5:0]      max_len_ff, max_len_in;
   logic [IW-1:0]   rd_idx_ff, rd_idx_in;
   logic [IW-1:0]   last_idx_ff, last_idx_in;
   logic            empty_ff, empty_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   logic            rsp_pvalid_ff, rsp_pvalid_in;
   logic [4:0]      rsp_index_ff, rsp_index_in;
   logic            rsp_last_ff, rsp_last_in;
   logic [7:0]      rd_data_ff;

   logic [7:0]      store_mem [MAX_FRAME];
   logic            mem_we;
   logic [7:0]      data_byte;
   logic [LW-1:0]   limit;
   logic [LW-1:0]   count_next;
   logic            csr_write;
   logic            crc_busy;
   logic            rd_busy;
   logic            empty_rsp;

   // limit saturated to the store depth
   assign limit = (LW'(max_len_ff) > LW'(MAX_FRAME)) ? LW'(MAX_FRAME) : LW'(max_len_ff);
   assign count_next = LW'(count_ff) + LW'(1);
   assign data_byte  = esc_ff ? (req_rx_byte ^ hfr_pkg::FLIP_MASK) : req_rx_byte;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr == hfr_pkg::CSR_MAX_LEN_ADDR);

   // next state and datapath
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      crc_in        = crc_ff;
      esc_in        = esc_ff;
      bit_cnt_in    = bit_cnt_ff;
      newest_in     = newest_ff;
      second_in     = second_ff;
      max_len_in    = max_len_ff;
      rd_idx_in     = rd_idx_ff;
      last_idx_in   = last_idx_ff;
      empty_in      = empty_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_pvalid_in = rsp_pvalid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;

      if (csr_write) begin
         max_len_in = csr_pwdata[5:0];
      end

      // output transfer frees the register
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority if (req_rx_byte == hfr_pkg::FLAG_OCTET) begin
                  esc_in   = 1'b0;
                  count_in = '0;
                  crc_in   = hfr_pkg::CRC_INIT;
                  if (!esc_ff && (count_ff >= CW'(2))
                      && ({newest_ff, second_ff} == crc_ff)) begin
                     empty_in    = (count_ff == CW'(2));
                     rd_idx_in   = '0;
                     last_idx_in = IW'(count_ff - CW'(3));
                     state_in    = ST_READ;
                  end
               end else if (!esc_ff && (req_rx_byte == hfr_pkg::ESC_OCTET)) begin
                  esc_in = 1'b1;
               end else begin
                  esc_in    = 1'b0;
                  mem_we    = 1'b1;
                  newest_in = data_byte;
                  second_in = newest_ff;
                  if (count_next >= limit) begin
                     count_in = '0;
                     crc_in   = hfr_pkg::CRC_INIT;
                  end else begin
                     count_in = CW'(count_next);
                     if (count_ff >= CW'(2)) begin
                        // feed the octet two back into the crc
                        crc_in     = crc_ff ^ {8'h00, second_ff};
                        bit_cnt_in = '0;
                        state_in   = ST_CRC;
                     end
                  end
               end
            end
         end
         ST_CRC: begin
            // one crc bit per cycle
            crc_in     = crc_ff[0] ? ((crc_ff >> 1) ^ hfr_pkg::CRC_POLY) : (crc_ff >> 1);
            bit_cnt_in = bit_cnt_ff + 3'd1;
            if (bit_cnt_ff == 3'd7) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (empty_ff) begin
                  rsp_byte_in   = 8'h00;
                  rsp_pvalid_in = 1'b0;
                  rsp_index_in  = 5'd0;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  rsp_byte_in   = rd_data_ff;
                  rsp_pvalid_in = 1'b1;
                  rsp_index_in  = 5'(rd_idx_ff);
                  rsp_last_in   = (rd_idx_ff == last_idx_ff);
                  if (rd_idx_ff == last_idx_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     rd_idx_in = rd_idx_ff + IW'(1);
                     state_in  = ST_READ;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         crc_ff       <= hfr_pkg::CRC_INIT;
         esc_ff       <= 1'b0;
         bit_cnt_ff   <= '0;
         max_len_ff   <= hfr_pkg::MAX_LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         crc_ff        <= crc_in;
         esc_ff        <= esc_in;
         bit_cnt_ff    <= bit_cnt_in;
         max_len_ff    <= max_len_in;
         rsp_valid_ff  <= rsp_valid_in;
         newest_ff     <= newest_in;
         second_ff     <= second_in;
         rd_idx_ff     <= rd_idx_in;
         last_idx_ff   <= last_idx_in;
         empty_ff      <= empty_in;
         rsp_byte_ff   <= rsp_byte_in;
         rsp_pvalid_ff <= rsp_pvalid_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // frame store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[count_ff[IW-1:0]] <= data_byte;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= store_mem[rd_idx_ff];
      end
   end

   // ports
   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_byte  = rsp_byte_ff;
   assign rsp_payload_valid = rsp_pvalid_ff;
   assign rsp_byte_index    = rsp_index_ff;
   assign rsp_last          = rsp_last_ff;
   assign csr_pready        = 1'b1;
   assign csr_prdata        = (csr_paddr == hfr_pkg::CSR_MAX_LEN_ADDR)
                              ? {26'd0, max_len_ff} : 32'd0;

   // check terms
   assign crc_busy  = (state_ff == ST_CRC) && (bit_cnt_ff != 3'd7);
   assign rd_busy   = (state_ff == ST_READ) || (state_ff == ST_LOAD);
   assign empty_rsp = rsp_valid_ff && !rsp_pvalid_ff;

   // checks
   `HFR_ASSERT_ALWAYS(a_count_in_range, count_ff < CW'(MAX_FRAME), "byte count beyond store")
   `HFR_ASSERT_NEXT(a_crc_runs_eight, crc_busy, state_ff == ST_CRC, "crc unit left early")
   `HFR_ASSERT_SAME(a_no_esc_in_output, rd_busy, !esc_ff && (count_ff == '0), "frame not cleared")
   `HFR_ASSERT_SAME(a_empty_is_last, empty_rsp, rsp_last_ff && (rsp_index_ff == 5'd0), "bad empty")

endmodule
